### rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the sorted list table: request and response
// transfers, request and status codes, and the controller-to-datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_LOCATE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t          req_type;
		logic signed [31:0] value;
		logic [6:0]         position;
	} slt_req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] value_out;
		logic [6:0]         found_position;
		logic [6:0]         entry_count;
	} slt_rsp_t;

	// Next value of the walk index
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_COUNT,
		IDX_ZERO,
		IDX_POS_M1,
		IDX_INC,
		IDX_DEC
	} idx_sel_t;

	// Table address: the walk index or the slot below it
	typedef enum logic {
		ADDR_IDX,
		ADDR_IDX_M1
	} addr_sel_t;

	// Table write data: the request value or the entry just read
	typedef enum logic {
		WD_VALUE,
		WD_READ
	} wdata_sel_t;

	typedef struct packed {
		logic       load;
		idx_sel_t   idx_sel;
		logic       rd_en;
		addr_sel_t  rd_addr_sel;
		logic       wr_en;
		addr_sel_t  wr_addr_sel;
		wdata_sel_t wr_data_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       set_status;
		status_t    status;
		logic       cap_value;
		logic       set_found;
	} slt_cmd_t;

	typedef struct packed {
		req_type_t req_type;
		logic      full;
		logic      pos_bad;
		logic      idx_zero;
		logic      idx_at_count;
		logic      rd_gt;
		logic      rd_eq;
	} slt_sts_t;

endpackage

### rtl/core/slt_datapath.sv
// ----------------------------------------------------------------------------
// slt_datapath
// Table memory, entry count, walk index, request latch and response
// registers. Acts on commands from the controller and reports compares.
// ----------------------------------------------------------------------------
module slt_datapath #(
	parameter int TABLE_DEPTH = slt_pkg::TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  slt_pkg::slt_req_t req,
	input  slt_pkg::slt_cmd_t cmd,
	output slt_pkg::slt_sts_t sts,
	output slt_pkg::slt_rsp_t rsp
);
	import slt_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = (CW > 7) ? CW : 7;

	logic [31:0]         mem_q [TABLE_DEPTH];
	logic [31:0]         rd_data_q;
	slt_req_t            req_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	status_t             status_q;
	logic signed [31:0]  vout_q;
	logic [6:0]          found_q;

	logic [CW-1:0]       idx_m1;
	logic [CW-1:0]       idx_p1;
	logic [CW-1:0]       pos_m1;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [31:0]         wr_data;
	logic [CW+6:0]       idx_p1_wide;
	logic [CW+6:0]       count_wide;

	assign idx_m1 = idx_q - 1'b1;
	assign idx_p1 = idx_q + 1'b1;
	assign pos_m1 = CW'(req_q.position) - 1'b1;

	// Select table addresses and write data
	assign rd_addr = (cmd.rd_addr_sel == ADDR_IDX) ? idx_q[AW-1:0] : idx_m1[AW-1:0];
	assign wr_addr = (cmd.wr_addr_sel == ADDR_IDX) ? idx_q[AW-1:0] : idx_m1[AW-1:0];
	assign wr_data = (cmd.wr_data_sel == WD_VALUE) ? req_q.value : rd_data_q;

	// Table memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Hold the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Latch the request, advance the walk index, update response fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req;
			status_q <= ST_OK;
			vout_q   <= '0;
			found_q  <= '0;
		end
		case (cmd.idx_sel)
			IDX_HOLD:   idx_q <= idx_q;
			IDX_COUNT:  idx_q <= count_q;
			IDX_ZERO:   idx_q <= '0;
			IDX_POS_M1: idx_q <= pos_m1;
			IDX_INC:    idx_q <= idx_p1;
			IDX_DEC:    idx_q <= idx_m1;
			default:    idx_q <= idx_q;
		endcase
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.cap_value) begin
			vout_q <= rd_data_q;
		end
		if (cmd.set_found) begin
			found_q <= idx_p1_wide[6:0];
		end
	end

	assign idx_p1_wide = {7'd0, idx_p1};
	assign count_wide  = {7'd0, count_q};

	// Report compares to the controller
	assign sts.req_type     = req_q.req_type;
	assign sts.full         = (count_q == CW'(TABLE_DEPTH));
	assign sts.pos_bad      = (req_q.position == 7'd0) ||
	                          (PW'(req_q.position) > PW'(count_q));
	assign sts.idx_zero     = (idx_q == '0);
	assign sts.idx_at_count = (idx_q == count_q);
	assign sts.rd_gt        = ($signed(rd_data_q) > req_q.value);
	assign sts.rd_eq        = (rd_data_q == req_q.value);

	assign rsp.status         = status_q;
	assign rsp.value_out      = vout_q;
	assign rsp.found_position = found_q;
	assign rsp.entry_count    = count_wide[6:0];

endmodule

### rtl/core/slt_ctrl.sv
// ----------------------------------------------------------------------------
// slt_ctrl
// Request sequencer. Dispatches each request, walks the table one entry
// at a time through the datapath, and presents the response transfer.
// ----------------------------------------------------------------------------
module slt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  slt_pkg::slt_sts_t sts,
	output slt_pkg::slt_cmd_t cmd
);
	import slt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_RD,
		S_INS_CMP,
		S_GP_RD,
		S_GP_CAP,
		S_DEL_RD,
		S_DEL_WR,
		S_LOC_RD,
		S_LOC_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   req_stall_q;
	logic   rsp_valid_q;

	assign req_stall = req_stall_q;
	assign rsp_valid = rsp_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.idx_sel     = IDX_HOLD;
		cmd.rd_addr_sel = ADDR_IDX;
		cmd.wr_addr_sel = ADDR_IDX;
		cmd.wr_data_sel = WD_VALUE;
		cmd.status      = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.req_type)
					REQ_INSERT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
							state_d        = S_DONE;
						end else begin
							cmd.idx_sel = IDX_COUNT;
							state_d     = S_INS_RD;
						end
					end
					REQ_DELETE, REQ_GET: begin
						if (sts.pos_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
							state_d        = S_DONE;
						end else begin
							cmd.idx_sel = IDX_POS_M1;
							state_d     = S_GP_RD;
						end
					end
					REQ_LOCATE: begin
						cmd.idx_sel = IDX_ZERO;
						state_d     = S_LOC_RD;
					end
					default: state_d = S_DONE;
				endcase
			end
			// Insert: read the entry below the free slot, or write the value at slot zero
			S_INS_RD: begin
				if (sts.idx_zero) begin
					cmd.wr_en   = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en       = 1'b1;
					cmd.rd_addr_sel = ADDR_IDX_M1;
					state_d         = S_INS_CMP;
				end
			end
			// Insert: shift a larger entry up, or drop the value in
			S_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.rd_gt) begin
					cmd.wr_data_sel = WD_READ;
					cmd.idx_sel     = IDX_DEC;
					state_d         = S_INS_RD;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_GP_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_GP_CAP;
			end
			S_GP_CAP: begin
				cmd.cap_value = 1'b1;
				if (sts.req_type == REQ_GET) begin
					state_d = S_DONE;
				end else begin
					cmd.idx_sel = IDX_INC;
					state_d     = S_DEL_RD;
				end
			end
			// Delete: move each following entry down one slot
			S_DEL_RD: begin
				if (sts.idx_at_count) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_addr_sel = ADDR_IDX_M1;
				cmd.wr_data_sel = WD_READ;
				cmd.idx_sel     = IDX_INC;
				state_d         = S_DEL_RD;
			end
			// Locate: scan upward until equal, larger, or end of table
			S_LOC_RD: begin
				if (sts.idx_at_count) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_LOC_CMP;
				end
			end
			S_LOC_CMP: begin
				if (sts.rd_eq) begin
					cmd.set_found = 1'b1;
					state_d       = S_DONE;
				end else if (sts.rd_gt) begin
					state_d = S_DONE;
				end else begin
					cmd.idx_sel = IDX_INC;
					state_d     = S_LOC_RD;
				end
			end
			S_DONE: begin
				if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_stall_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			req_stall_q <= (state_d != S_IDLE);
			rsp_valid_q <= (state_d == S_DONE);
		end
	end

endmodule

### rtl/core/sorted_list_table.sv
// Sorted list table: one request in flight at a time, one response each.
// Insert moves each larger entry up one slot, delete moves each following entry
// down one slot, and locate passes each smaller entry until it meets an equal or
// larger one or the end of the table. The next request can be accepted in the
// cycle after the response transfer. Reset clears the entry count; table contents
// stay undefined.
// ----------------------------------------------------------------------------
// sorted_list_table
// Ascending table of signed 32-bit values with insert, delete, get and
// locate requests, built as a sequencer over a table memory datapath.
// ----------------------------------------------------------------------------
module sorted_list_table #(
	parameter int TABLE_DEPTH = slt_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  slt_pkg::slt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output slt_pkg::slt_rsp_t rsp
);
	import slt_pkg::*;

	slt_cmd_t cmd;
	slt_sts_t sts;

	// Sequence requests
	slt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the table and response
	slt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
